FILE: design/arp_pkg.sv
// arp_pkg: shared types, constants and header rewrite functions for the
// arp reply / udp reflect block; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package arp_pkg;

    localparam int HEADER_BYTES = 42;
    localparam int MAX_FRAME    = 2048;
    localparam int CNT_W        = $clog2(MAX_FRAME + 1);
    localparam int HDR_AW       = $clog2(HEADER_BYTES);
    localparam int LEN_W        = $clog2(HEADER_BYTES + 1);
    localparam int MIN_LEN_W    = 7;
    localparam int MAC_W        = 48;

    localparam logic [MAC_W-1:0]     OWN_MAC_RST = 48'h000111111111;
    localparam logic [MIN_LEN_W-1:0] MIN_LEN_RST = 7'd40;

    localparam logic [15:0] ETYPE_ARP  = 16'h0806;
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ARP_HTYPE  = 16'h0001;
    localparam logic [7:0]  ARP_HLEN   = 8'd6;
    localparam logic [7:0]  ARP_PLEN   = 8'd4;
    localparam logic [15:0] ARP_REQ    = 16'h0001;
    localparam logic [7:0]  ARP_REP_HI = 8'h00;
    localparam logic [7:0]  ARP_REP_LO = 8'h02;
    localparam logic [7:0]  IP_UDP     = 8'd17;

    // one entry of the queue between front and back end
    typedef struct packed {
        logic             is_hdr;   // header job, else one payload byte
        logic             is_arp;   // header job: arp reply, else udp swap
        logic [LEN_W-1:0] len;      // header job: bytes to emit
        logic [7:0]       data;     // payload byte
        logic             last;
    } t_job;

    // back end to front end: header store read port and release
    typedef struct packed {
        logic              hdr_done;
        logic [HDR_AW-1:0] rd_addr;
    } t_b2f;

    typedef enum logic [1:0] {
        SRC_STORE,
        SRC_MAC,
        SRC_CONST
    } t_srcsel;

    typedef struct packed {
        t_srcsel           sel;
        logic [HDR_AW-1:0] addr;
        logic [2:0]        mac_j;
        logic [7:0]        cval;
    } t_src;

    // where output header byte idx comes from after the rewrite
    function automatic t_src hdr_src(input logic is_arp, input logic [HDR_AW-1:0] idx);
        t_src s;
        s.sel   = SRC_STORE;
        s.addr  = idx;
        s.mac_j = '0;
        s.cval  = '0;
        if (is_arp) begin
            case (idx) inside
                [6'd0:6'd5]: begin
                    s.addr = idx + 6'd6;
                end
                [6'd6:6'd11]: begin
                    s.sel   = SRC_MAC;
                    s.mac_j = 3'(idx - 6'd6);
                end
                6'd20: begin
                    s.sel  = SRC_CONST;
                    s.cval = ARP_REP_HI;
                end
                6'd21: begin
                    s.sel  = SRC_CONST;
                    s.cval = ARP_REP_LO;
                end
                [6'd22:6'd27]: begin
                    s.sel   = SRC_MAC;
                    s.mac_j = 3'(idx - 6'd22);
                end
                [6'd28:6'd31]: begin
                    s.addr = idx + 6'd10;
                end
                [6'd32:6'd41]: begin
                    s.addr = idx - 6'd10;
                end
                default: begin
                end
            endcase
        end else begin
            case (idx) inside
                [6'd0:6'd5]:   s.addr = idx + 6'd6;
                [6'd6:6'd11]:  s.addr = idx - 6'd6;
                [6'd26:6'd29]: s.addr = idx + 6'd4;
                [6'd30:6'd33]: s.addr = idx - 6'd4;
                [6'd34:6'd35]: s.addr = idx + 6'd2;
                [6'd36:6'd37]: s.addr = idx - 6'd2;
                default: begin
                end
            endcase
        end
        return s;
    endfunction

    // byte j of the mac, byte 0 most significant
    function automatic logic [7:0] mac_byte(input logic [MAC_W-1:0] mac, input logic [2:0] j);
        logic [MAC_W-1:0] sh;
        sh = mac >> {3'd5 - j, 3'b000};
        return sh[7:0];
    endfunction

endpackage

`default_nettype wire

FILE: design/arp_front.sv
// arp_front: accepts frame bytes, holds the header store and classifies
// each frame; depends on arp_pkg
`timescale 1ns / 1ps
`default_nettype none

module arp_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [7:0]                     i_in_byte,
    input  wire logic                           i_in_last,
    input  wire logic                           i_push,
    output logic                                o_full,
    input  wire logic [arp_pkg::MIN_LEN_W-1:0]  i_min_length,
    output logic                                o_job_push,
    output arp_pkg::t_job                       o_job,
    input  wire logic                           i_q_full,
    input  arp_pkg::t_b2f                       i_b2f,
    output logic [7:0]                          o_rd_data
);

    localparam int CAP_BASE = 12;
    localparam int CAP_N    = 12;

    typedef enum logic [1:0] {
        V_UNDECIDED = 2'd0,
        V_FORWARD   = 2'd1,
        V_DROP      = 2'd2
    } t_verdict;

    t_verdict                            r_verdict;
    logic [arp_pkg::CNT_W-1:0]           r_cnt;
    logic                                r_hdr_busy;
    logic [arp_pkg::HEADER_BYTES-1:0]    r_vld;
    logic [arp_pkg::HEADER_BYTES-1:0]    n_vld;
    logic [7:0]                          r_mem [arp_pkg::HEADER_BYTES];
    logic [7:0]                          r_cap [CAP_N];
    logic [7:0]                          f [CAP_N];
    logic [7:0]                          r_rd_data;

    logic                                acc;
    logic                                undecided;
    logic [arp_pkg::CNT_W-1:0]           cnt_nx;
    logic                                decide;
    logic                                arp_ok;
    logic                                udp_ok;
    logic [arp_pkg::MIN_LEN_W-1:0]       need;
    logic [arp_pkg::LEN_W-1:0]           len;
    logic                                fwd;
    logic [arp_pkg::HDR_AW-1:0]          widx;

    assign undecided = (r_verdict == V_UNDECIDED);
    // hold new header bytes back while the back end still reads the store
    assign o_full    = i_q_full || (r_hdr_busy && undecided);
    assign acc       = i_push && !o_full;
    assign widx      = r_cnt[arp_pkg::HDR_AW-1:0];

    always_comb begin
        cnt_nx = (r_cnt < arp_pkg::CNT_W'(arp_pkg::MAX_FRAME)) ? r_cnt + 1'b1 : r_cnt;
        // classification bytes as they stand after this byte
        for (int k = 0; k < CAP_N; k++) begin
            if (r_cnt == arp_pkg::CNT_W'(CAP_BASE + k)) begin
                f[k] = i_in_byte;
            end else if (r_cnt == '0) begin
                f[k] = '0;
            end else begin
                f[k] = r_cap[k];
            end
        end
        n_vld = (r_cnt == '0) ? '0 : r_vld;
        n_vld[widx] = 1'b1;
        decide = (cnt_nx >= arp_pkg::CNT_W'(arp_pkg::HEADER_BYTES)) || i_in_last;
        len    = cnt_nx[arp_pkg::LEN_W-1:0];
        need   = (i_min_length > arp_pkg::MIN_LEN_W'(arp_pkg::HEADER_BYTES))
               ? arp_pkg::MIN_LEN_W'(arp_pkg::HEADER_BYTES) : i_min_length;
        arp_ok = ({f[0], f[1]} == arp_pkg::ETYPE_ARP) && ({f[2], f[3]} == arp_pkg::ARP_HTYPE)
              && ({f[4], f[5]} == arp_pkg::ETYPE_IPV4) && (f[6] == arp_pkg::ARP_HLEN)
              && (f[7] == arp_pkg::ARP_PLEN) && ({f[8], f[9]} == arp_pkg::ARP_REQ);
        udp_ok = ({f[0], f[1]} == arp_pkg::ETYPE_IPV4) && (f[11] == arp_pkg::IP_UDP);
        fwd    = ({1'b0, len} >= need) && (arp_ok || udp_ok);
    end

    assign o_job_push    = acc && ((undecided && decide && fwd) || (r_verdict == V_FORWARD));
    assign o_job.is_hdr  = undecided;
    assign o_job.is_arp  = arp_ok;
    assign o_job.len     = len;
    assign o_job.data    = i_in_byte;
    assign o_job.last    = i_in_last;
    assign o_rd_data     = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_verdict  <= V_UNDECIDED;
            r_cnt      <= '0;
            r_hdr_busy <= 1'b0;
            r_vld      <= '0;
        end else begin
            if (i_b2f.hdr_done) begin
                r_hdr_busy <= 1'b0;
            end
            if (acc) begin
                r_cnt <= cnt_nx;
                if (undecided) begin
                    r_vld <= n_vld;
                    if (decide) begin
                        r_verdict <= fwd ? V_FORWARD : V_DROP;
                        if (fwd) begin
                            r_hdr_busy <= 1'b1;
                        end
                    end
                end
                if (i_in_last) begin
                    r_cnt     <= '0;
                    r_verdict <= V_UNDECIDED;
                end
            end
        end
    end

    // header store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (acc && undecided) begin
            r_mem[widx] <= i_in_byte;
            for (int k = 0; k < CAP_N; k++) begin
                r_cap[k] <= f[k];
            end
        end
        r_rd_data <= r_vld[i_b2f.rd_addr] ? r_mem[i_b2f.rd_addr] : 8'h00;
    end

    a_hdr_push_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_job_push && o_job.is_hdr) |-> !r_hdr_busy)
        else $error("header job pushed while store still in use");

    a_undecided_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_verdict == V_UNDECIDED) |-> (r_cnt < arp_pkg::CNT_W'(arp_pkg::HEADER_BYTES)))
        else $error("undecided frame past header length");

endmodule

`default_nettype wire

FILE: design/arp_jobq.sv
// arp_jobq: short queue of jobs between the front and the back end
// depends on arp_pkg
`timescale 1ns / 1ps
`default_nettype none

module arp_jobq (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  arp_pkg::t_job i_job,
    output logic         o_full,
    input  wire logic    i_pop,
    output arp_pkg::t_job o_job,
    output logic         o_empty
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    arp_pkg::t_job  r_q [DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;
    logic           wr;
    logic           rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_job   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(wr) - CW'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= i_job;
        end
    end

endmodule

`default_nettype wire

FILE: design/arp_back.sv
// arp_back: expands header jobs into rewritten header bytes, passes payload
// bytes and buffers results; depends on arp_pkg
`timescale 1ns / 1ps
`default_nettype none

module arp_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  arp_pkg::t_job                   i_job,
    input  wire logic                       i_q_empty,
    output logic                            o_q_pop,
    input  wire logic [arp_pkg::MAC_W-1:0]  i_own_mac,
    output arp_pkg::t_b2f                   o_b2f,
    input  wire logic [7:0]                 i_rd_data,
    output logic [7:0]                      o_out_byte,
    output logic                            o_out_last,
    output logic                            o_empty,
    input  wire logic                       i_pop
);

    localparam int OD  = 4;
    localparam int OPW = $clog2(OD);
    localparam int OCW = $clog2(OD + 1);

    typedef enum logic {
        B_PASS,
        B_HDR
    } t_bstate;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_obyte;

    t_bstate                      r_state;
    logic [arp_pkg::HDR_AW-1:0]   r_idx;
    logic [arp_pkg::LEN_W-1:0]    r_len;
    logic                         r_is_arp;
    logic                         r_last;
    logic                         r_s1_vld;
    logic                         r_s1_store;
    logic [7:0]                   r_s1_byte;
    logic                         r_s1_last;
    t_obyte                       r_of [OD];
    logic [OPW-1:0]               r_wp;
    logic [OPW-1:0]               r_rp;
    logic [OCW-1:0]               r_ocnt;

    arp_pkg::t_src                src;
    logic                         can_issue;
    logic                         last_idx;
    logic                         issue_hdr;
    logic                         issue_data;
    logic                         opop;

    always_comb begin
        src        = arp_pkg::hdr_src(r_is_arp, r_idx);
        // room for the byte in flight and one more
        can_issue  = ((OCW + 1)'(r_ocnt) + (OCW + 1)'(r_s1_vld)) < (OCW + 1)'(OD);
        last_idx   = ({1'b0, r_idx} == (r_len - 1'b1));
        issue_hdr  = (r_state == B_HDR) && can_issue;
        o_q_pop    = (r_state == B_PASS) && !i_q_empty && can_issue;
        issue_data = o_q_pop && !i_job.is_hdr;
        opop       = i_pop && !o_empty;
    end

    assign o_b2f.rd_addr  = src.addr;
    assign o_b2f.hdr_done = issue_hdr && last_idx;
    assign o_empty        = (r_ocnt == '0);
    assign o_out_byte     = r_of[r_rp].data;
    assign o_out_last     = r_of[r_rp].last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_PASS;
            r_idx      <= '0;
            r_len      <= '0;
            r_is_arp   <= 1'b0;
            r_last     <= 1'b0;
            r_s1_vld   <= 1'b0;
            r_s1_store <= 1'b0;
            r_s1_byte  <= '0;
            r_s1_last  <= 1'b0;
            r_wp       <= '0;
            r_rp       <= '0;
            r_ocnt     <= '0;
        end else begin
            case (r_state)
                B_PASS: begin
                    if (o_q_pop && i_job.is_hdr) begin
                        r_state  <= B_HDR;
                        r_idx    <= '0;
                        r_len    <= i_job.len;
                        r_is_arp <= i_job.is_arp;
                        r_last   <= i_job.last;
                    end
                end
                B_HDR: begin
                    if (issue_hdr) begin
                        r_idx <= r_idx + 1'b1;
                        if (last_idx) begin
                            r_state <= B_PASS;
                        end
                    end
                end
                default: r_state <= B_PASS;
            endcase

            r_s1_vld <= issue_hdr || issue_data;
            if (issue_hdr) begin
                r_s1_store <= (src.sel == arp_pkg::SRC_STORE);
                r_s1_byte  <= (src.sel == arp_pkg::SRC_MAC)
                            ? arp_pkg::mac_byte(i_own_mac, src.mac_j) : src.cval;
                r_s1_last  <= r_last && last_idx;
            end else if (issue_data) begin
                r_s1_store <= 1'b0;
                r_s1_byte  <= i_job.data;
                r_s1_last  <= i_job.last;
            end

            if (r_s1_vld) begin
                r_wp <= r_wp + 1'b1;
            end
            if (opop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_ocnt <= r_ocnt + OCW'(r_s1_vld) - OCW'(opop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_of[r_wp] <= '{data: (r_s1_store ? i_rd_data : r_s1_byte), last: r_s1_last};
        end
    end

    a_ofifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= OCW'(OD))
        else $error("result buffer overflow");

    a_idx_in_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_HDR) |-> ({1'b0, r_idx} < r_len))
        else $error("header index past header length");

    a_done_ends_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_b2f.hdr_done |=> (r_state == B_PASS))
        else $error("header emission did not end after release");

endmodule

`default_nettype wire

FILE: design/arp_reply_udp_reflect.sv
// arp_reply_udp_reflect: top level with configuration registers, front end,
// job queue and back end; depends on arp_pkg, arp_front, arp_jobq, arp_back
`timescale 1ns / 1ps
`default_nettype none

// Ethernet frame bytes (no FCS) come in one per push, in_last on the final
// byte. ARP requests are answered with a reply from own_mac, IPv4/UDP frames
// go back out with MAC, IP and port pairs swapped (checksums untouched),
// everything else and frames shorter than min_length (capped at 42) are
// dropped. The front end stores the first 42 bytes and decides at byte 42 or
// at in_last; the back end then reads the rewritten header out of the store
// at one byte per cycle while the result buffer has room, and the payload
// bytes keep flowing in behind it through a four entry job queue. Payload
// and dropped frames run at one byte per cycle unless the job queue is full.
// The first byte of the next frame waits until the back end has read the
// whole header of a forwarded frame, since it would overwrite the header
// store. Registers: own_mac at byte address 0, min_length at byte address 8,
// 64 bit data; the user must make writes only while no frame is in progress;
// the block does not enforce this.
module arp_reply_udp_reflect (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    // incoming frame bytes
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_in_last,
    input  wire logic        push,
    output logic             full,
    // outgoing frame bytes
    output logic [7:0]       o_out_byte,
    output logic             o_out_last,
    output logic             empty,
    input  wire logic        pop
);

    logic [arp_pkg::MAC_W-1:0]     r_own_mac;
    logic [arp_pkg::MIN_LEN_W-1:0] r_min_length;
    logic                          cfg_wr;

    arp_pkg::t_job                 fe_job;
    logic                          fe_job_push;
    arp_pkg::t_job                 q_job;
    logic                          q_full;
    logic                          q_empty;
    logic                          q_pop;
    arp_pkg::t_b2f                 b2f;
    logic [7:0]                    rd_data;

    // register file, paddr[3] picks the register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = paddr[3] ? {{(64 - arp_pkg::MIN_LEN_W){1'b0}}, r_min_length}
                             : {{(64 - arp_pkg::MAC_W){1'b0}}, r_own_mac};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mac    <= arp_pkg::OWN_MAC_RST;
            r_min_length <= arp_pkg::MIN_LEN_RST;
        end else if (cfg_wr) begin
            if (paddr[3]) begin
                r_min_length <= pwdata[arp_pkg::MIN_LEN_W-1:0];
            end else begin
                r_own_mac <= pwdata[arp_pkg::MAC_W-1:0];
            end
        end
    end

    // front end: header capture and classification
    arp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_byte    (i_in_byte),
        .i_in_last    (i_in_last),
        .i_push       (push),
        .o_full       (full),
        .i_min_length (r_min_length),
        .o_job_push   (fe_job_push),
        .o_job        (fe_job),
        .i_q_full     (q_full),
        .i_b2f        (b2f),
        .o_rd_data    (rd_data)
    );

    // decouples classification from emission
    arp_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_job_push),
        .i_job   (fe_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (q_job),
        .o_empty (q_empty)
    );

    // back end: header rewrite, payload pass and result buffer
    arp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (q_job),
        .i_q_empty  (q_empty),
        .o_q_pop    (q_pop),
        .i_own_mac  (r_own_mac),
        .o_b2f      (b2f),
        .i_rd_data  (rd_data),
        .o_out_byte (o_out_byte),
        .o_out_last (o_out_last),
        .o_empty    (empty),
        .i_pop      (pop)
    );

endmodule

`default_nettype wire
